>>> sv/cpc_pkg.sv
// Shared types, codes and helper functions for the column prelude checker.
package cpc_pkg;

    typedef enum logic [2:0] {
        PH_VER,
        PH_FLAGS,
        PH_N,
        PH_M,
        PH_LENS,
        PH_BODY,
        PH_DEAD
    } t_phase;

    localparam logic [3:0] ST_OK      = 4'd0;
    localparam logic [3:0] ST_SHORT   = 4'd1;
    localparam logic [3:0] ST_CRC     = 4'd2;
    localparam logic [3:0] ST_VERSION = 4'd3;
    localparam logic [3:0] ST_HEADER  = 4'd4;
    localparam logic [3:0] ST_CAP     = 4'd5;
    localparam logic [3:0] ST_OVER    = 4'd6;
    localparam logic [3:0] ST_UNDER   = 4'd7;
    localparam logic [3:0] ST_COLUMN  = 4'd8;

    localparam logic [2:0] COL_MAXFREQ = 3'd0;
    localparam logic [2:0] COL_MAXNORM = 3'd1;
    localparam logic [2:0] COL_DOCDELTA = 3'd2;
    localparam logic [2:0] COL_WINLEN  = 3'd3;
    localparam logic [2:0] COL_POSCUM  = 3'd4;
    localparam logic [2:0] COL_WINCRC  = 3'd5;
    localparam logic [2:0] COL_DONE    = 3'd6;

    localparam logic KIND_VALUE   = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // bit positions in the error vector
    localparam int ERR_VER  = 0;
    localparam int ERR_HDR  = 1;
    localparam int ERR_CAP  = 2;
    localparam int ERR_OVER = 3;
    localparam int ERR_COL  = 4;

    localparam logic [1:0] CFG_VERSION = 2'd0;
    localparam logic [1:0] CFG_FREQ    = 2'd1;
    localparam logic [1:0] CFG_PRX     = 2'd2;

    localparam logic [31:0] CRC_POLY = 32'h82F63B78;

    typedef struct packed {
        logic        kind;
        logic [2:0]  column;
        logic [23:0] entry_index;
        logic [63:0] value;
        logic        freq_present;
        logic        prx_present;
        logic [24:0] window_count;
        logic [24:0] position_count;
        logic [3:0]  status;
    } t_result;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    function automatic logic [2:0] next_col(input logic [2:0] c, input logic prx);
        logic [2:0] r;
        case (c)
            COL_MAXFREQ:  r = COL_MAXNORM;
            COL_MAXNORM:  r = COL_DOCDELTA;
            COL_DOCDELTA: r = COL_WINLEN;
            COL_WINLEN:   r = prx ? COL_POSCUM : COL_WINCRC;
            COL_POSCUM:   r = COL_WINCRC;
            default:      r = COL_DONE;
        endcase
        return r;
    endfunction

    function automatic logic is_varint_col(input logic [2:0] c);
        return (c == COL_MAXFREQ) || (c == COL_DOCDELTA) || (c == COL_WINLEN) ||
               (c == COL_POSCUM);
    endfunction

    function automatic logic [3:0] header_code(input logic [4:0] e);
        logic [3:0] r;
        if (e[ERR_VER]) begin
            r = ST_VERSION;
        end else if (e[ERR_HDR]) begin
            r = ST_HEADER;
        end else begin
            r = ST_CAP;
        end
        return r;
    endfunction

endpackage

>>> sv/column_prelude_checker.sv
// Column prelude checker: header parse, column decode, CRC-32C and final verdict.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+--------------------------------------------
//   in       | i_valid / o_ready     | i_byte_value, i_last
//   out      | o_valid / i_ready     | o_kind .. o_status (one result per transfer)
//   config   | i_cfg_we              | i_cfg_index, i_cfg_data
//
// One byte per cycle while o_ready is high: a byte is fully handled in the cycle it
// leaves the four-byte tail, and up to two results go into a four-entry output queue.
// o_ready drops while the queue holds more than two results. When the last byte arrives
// with the header still open, the header parser walks the four CRC bytes, one per cycle
// (no input taken), before the verdict. Reset is synchronous; no clearing pass.
module column_prelude_checker #(
    parameter int WINDOW_CAP_LOG2 = 24,
    parameter int LENGTH_BITS     = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte_value,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [2:0]  o_column,
    output logic [23:0] o_entry_index,
    output logic [63:0] o_value,
    output logic        o_freq_present,
    output logic        o_prx_present,
    output logic [24:0] o_window_count,
    output logic [24:0] o_position_count,
    output logic [3:0]  o_status,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    localparam int CW = WINDOW_CAP_LOG2 + 1;
    localparam int LB = LENGTH_BITS;
    localparam int SW = LENGTH_BITS + 3;
    localparam logic [63:0]   CAP64 = 64'd1 << WINDOW_CAP_LOG2;
    localparam logic [CW-1:0] CAP1  = CAP64[CW-1:0] + CW'(1);

    // configuration
    logic [7:0] r_ev, r_fm, r_pm;

    // parse state
    logic [7:0]  r_tail [4];
    logic [7:0]  n_tail [4];
    logic [2:0]  r_fill, n_fill;
    logic [31:0] r_crc, n_crc;
    cpc_pkg::t_phase r_phase, n_phase;
    logic [63:0] r_vacc, n_vacc;
    logic [3:0]  r_vsh, n_vsh;
    logic [CW-1:0] r_win, n_win, r_pos, n_pos;
    logic [LB-1:0] r_len [6];
    logic [LB-1:0] n_len [6];
    logic [SW-1:0] r_sum, n_sum, r_body, n_body;
    logic [2:0]  r_col, n_col;
    logic [LB-1:0] r_left, n_left;
    logic [CW-1:0] r_ent, n_ent;
    logic [4:0]  r_err, n_err;
    logic [1:0]  r_flags, n_flags;
    logic        r_drain, n_drain;
    logic [1:0]  r_didx, n_didx;
    logic        r_crc_bad, n_crc_bad;

    logic accept;
    logic q_room, q_valid;
    logic [1:0] wr_cnt;
    cpc_pkg::t_result wr_d0, wr_d1, q_head;
    logic [CW-1:0] w_cur_count;

    assign o_ready = !r_drain && q_room;
    assign accept  = i_valid && o_ready;
    assign w_cur_count = (r_col == cpc_pkg::COL_POSCUM) ? r_pos : r_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= 8'd1;
            r_fm <= 8'd1;
            r_pm <= 8'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cpc_pkg::CFG_VERSION: r_ev <= i_cfg_data;
                cpc_pkg::CFG_FREQ:    r_fm <= i_cfg_data;
                cpc_pkg::CFG_PRX:     r_pm <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [7:0]  pb;
        logic        proc, prx, got, vpush, hdr_ok, clr;
        logic [3:0]  sh9, sh_inc, hs, stt;
        logic [6:0]  sh7;
        logic [63:0] vf, v, win64, pos64, ent64;
        logic [LB-1:0] lv;
        logic [2:0]  total, k, code, c;
        logic [2:0]  got_col;
        logic [CW-1:0] got_idx, cnt;
        logic [63:0] got_val;
        logic [63:0] acc5;
        logic        ef_go, ef_stop, ef_err;
        logic [2:0]  ef_start, ef_c;
        logic [5:0]  zero, eerr, cerr;
        logic [31:0] stored;
        logic        crc_bad;
        logic        fp_o, pp_o;
        logic [CW-1:0] wc_o, pc_o;

        n_tail = r_tail;   n_fill = r_fill;   n_crc = r_crc;     n_phase = r_phase;
        n_vacc = r_vacc;   n_vsh = r_vsh;     n_win = r_win;     n_pos = r_pos;
        n_len = r_len;     n_sum = r_sum;     n_body = r_body;   n_col = r_col;
        n_left = r_left;   n_ent = r_ent;     n_err = r_err;     n_flags = r_flags;
        n_drain = r_drain; n_didx = r_didx;   n_crc_bad = r_crc_bad;

        pb   = r_drain ? r_tail[r_didx] : r_tail[0];
        proc = r_drain || (accept && r_fill[2]);
        prx  = r_flags[1];

        if (accept) begin
            if (r_fill[2]) begin
                n_tail[0] = r_tail[1];
                n_tail[1] = r_tail[2];
                n_tail[2] = r_tail[3];
                n_tail[3] = i_byte_value;
                n_crc = cpc_pkg::crc_byte(r_crc, r_tail[0]);
            end else begin
                n_tail[r_fill[1:0]] = i_byte_value;
                n_fill = r_fill + 3'd1;
            end
        end

        // shared LEB128 step
        sh9    = (r_vsh > 4'd9) ? 4'd9 : r_vsh;
        sh7    = {sh9, 3'b000} - {3'b000, sh9};
        vf     = r_vacc | ({57'd0, pb[6:0]} << sh7);
        sh_inc = sh9 + 4'd1;
        v = vf;

        got = 1'b0; got_col = r_col; got_idx = r_ent; got_val = 64'd0;
        ef_go = 1'b0; ef_start = cpc_pkg::COL_MAXFREQ;
        total = prx ? 3'd6 : 3'd5;
        k = (r_col >= total) ? total - 3'd1 : r_col;
        code = (k == cpc_pkg::COL_POSCUM && !prx) ? cpc_pkg::COL_WINCRC : k;
        lv = v[LB-1:0];
        c = r_col;
        cnt = w_cur_count;
        acc5 = r_vacc | ({56'd0, pb} << {r_vsh[1:0], 3'b000});

        if (proc && r_phase != cpc_pkg::PH_BODY && r_phase != cpc_pkg::PH_DEAD) begin
            case (r_phase)
                cpc_pkg::PH_VER: begin
                    if (pb != r_ev) begin
                        n_err[cpc_pkg::ERR_VER] = 1'b1;
                        n_phase = cpc_pkg::PH_DEAD;
                    end else begin
                        n_phase = cpc_pkg::PH_FLAGS;
                    end
                end
                cpc_pkg::PH_FLAGS: begin
                    n_flags = {|(pb & r_pm), |(pb & r_fm)};
                    n_phase = cpc_pkg::PH_N;
                end
                cpc_pkg::PH_N, cpc_pkg::PH_M: begin
                    if (pb[7] && sh_inc >= 4'd10) begin
                        n_err[cpc_pkg::ERR_HDR] = 1'b1;
                        n_phase = cpc_pkg::PH_DEAD;
                        n_vacc = 64'd0;
                        n_vsh = 4'd0;
                    end else if (pb[7]) begin
                        n_vacc = vf;
                        n_vsh = sh_inc;
                    end else begin
                        n_vacc = 64'd0;
                        n_vsh = 4'd0;
                        if (r_phase == cpc_pkg::PH_N) begin
                            n_win = (v > CAP64) ? CAP1 : v[CW-1:0];
                        end else begin
                            n_pos = (v > CAP64) ? CAP1 : v[CW-1:0];
                        end
                        if (r_phase == cpc_pkg::PH_N && prx) begin
                            n_phase = cpc_pkg::PH_M;
                        end else if (n_win == CAP1 || n_pos == CAP1) begin
                            n_err[cpc_pkg::ERR_CAP] = 1'b1;
                            n_phase = cpc_pkg::PH_DEAD;
                        end else begin
                            n_phase = cpc_pkg::PH_LENS;
                            n_col = cpc_pkg::COL_MAXFREQ;
                        end
                    end
                end
                cpc_pkg::PH_LENS: begin
                    if (pb[7] && sh_inc >= 4'd10) begin
                        n_err[cpc_pkg::ERR_HDR] = 1'b1;
                        n_phase = cpc_pkg::PH_DEAD;
                        n_vacc = 64'd0;
                        n_vsh = 4'd0;
                    end else if (pb[7]) begin
                        n_vacc = vf;
                        n_vsh = sh_inc;
                    end else begin
                        n_vacc = 64'd0;
                        n_vsh = 4'd0;
                        if (v[63:LB] != '0) begin
                            n_err[cpc_pkg::ERR_OVER] = 1'b1;
                            lv = '1;
                        end
                        n_len[code] = lv;
                        n_sum = r_sum + SW'(lv);
                        if (k + 3'd1 >= total) begin
                            n_phase = cpc_pkg::PH_BODY;
                            n_body = '0;
                            ef_go = 1'b1;
                            ef_start = cpc_pkg::COL_MAXFREQ;
                        end else begin
                            n_col = k + 3'd1;
                        end
                    end
                end
                default: ;
            endcase
        end else if (proc && r_phase == cpc_pkg::PH_BODY && !r_drain) begin
            if (!(&r_body)) begin
                n_body = r_body + SW'(1);
            end
            if (c < cpc_pkg::COL_DONE) begin
                n_left = r_left - LB'(1);
                if (c == cpc_pkg::COL_MAXNORM) begin
                    if (r_ent < cnt) begin
                        got = 1'b1;
                        got_val = {56'd0, pb};
                        n_ent = r_ent + CW'(1);
                    end
                end else if (c == cpc_pkg::COL_WINCRC) begin
                    if (r_vsh + 4'd1 >= 4'd4) begin
                        if (r_ent < cnt) begin
                            got = 1'b1;
                            got_val = acc5;
                            n_ent = r_ent + CW'(1);
                        end
                        n_vacc = 64'd0;
                        n_vsh = 4'd0;
                    end else begin
                        n_vacc = acc5;
                        n_vsh = r_vsh + 4'd1;
                    end
                end else if (r_ent >= cnt) begin
                    n_err[cpc_pkg::ERR_COL] = 1'b1;
                end else if (pb[7] &&
                             sh_inc >= ((c == cpc_pkg::COL_POSCUM) ? 4'd10 : 4'd5)) begin
                    n_err[cpc_pkg::ERR_COL] = 1'b1;
                    n_ent = cnt;
                    n_vacc = 64'd0;
                    n_vsh = 4'd0;
                end else if (pb[7]) begin
                    n_vacc = vf;
                    n_vsh = sh_inc;
                end else begin
                    got = 1'b1;
                    got_val = (c == cpc_pkg::COL_POSCUM) ? vf : {32'd0, vf[31:0]};
                    n_ent = r_ent + CW'(1);
                    n_vacc = 64'd0;
                    n_vsh = 4'd0;
                end
                if (r_left == LB'(1)) begin
                    if (cpc_pkg::is_varint_col(c) && (n_vsh != 4'd0 || n_ent != cnt)) begin
                        n_err[cpc_pkg::ERR_COL] = 1'b1;
                    end
                    ef_go = 1'b1;
                    ef_start = cpc_pkg::next_col(c, prx);
                end
            end
        end

        // walk into the next column that has bytes, checking empty ones on the way
        win64 = 64'(n_win);
        pos64 = 64'(n_pos);
        for (int j = 0; j < 6; j++) begin
            zero[j] = (n_len[j] == '0);
            eerr[j] = 1'b0;
            cerr[j] = cpc_pkg::is_varint_col(3'(j)) &&
                      (((j == int'(cpc_pkg::COL_POSCUM)) ? pos64 : win64) != 64'd0);
        end
        eerr[cpc_pkg::COL_MAXNORM] = (64'(n_len[cpc_pkg::COL_MAXNORM]) != win64);
        eerr[cpc_pkg::COL_WINCRC]  = (64'(n_len[cpc_pkg::COL_WINCRC]) !=
                                      {win64[61:0], 2'b00});
        ef_c = ef_start;
        ef_stop = 1'b0;
        ef_err = 1'b0;
        for (int s = 0; s < 6; s++) begin
            if (!ef_stop && ef_c < cpc_pkg::COL_DONE) begin
                if (eerr[ef_c]) ef_err = 1'b1;
                if (!zero[ef_c]) begin
                    ef_stop = 1'b1;
                end else begin
                    if (cerr[ef_c]) ef_err = 1'b1;
                    ef_c = cpc_pkg::next_col(ef_c, n_flags[1]);
                end
            end
        end
        if (ef_go) begin
            n_col = ef_c;
            n_ent = '0;
            n_vacc = 64'd0;
            n_vsh = 4'd0;
            if (ef_err) n_err[cpc_pkg::ERR_COL] = 1'b1;
            if (ef_c < cpc_pkg::COL_DONE) n_left = n_len[ef_c];
        end

        // verdict
        vpush = 1'b0; hdr_ok = 1'b0; clr = 1'b0; stt = cpc_pkg::ST_OK; hs = cpc_pkg::ST_OK;
        stored = {n_tail[3], n_tail[2], n_tail[1], n_tail[0]};
        crc_bad = (~n_crc != stored);
        if (r_drain) begin
            if (n_phase == cpc_pkg::PH_DEAD) begin
                hs = cpc_pkg::header_code(n_err);
            end else if (n_phase == cpc_pkg::PH_BODY) begin
                hs = cpc_pkg::ST_OVER;
                hdr_ok = 1'b1;
            end else begin
                hs = cpc_pkg::ST_HEADER;
            end
            if (n_phase == cpc_pkg::PH_DEAD || n_phase == cpc_pkg::PH_BODY ||
                r_didx == 2'd3) begin
                vpush = 1'b1;
                stt = r_crc_bad ? cpc_pkg::ST_CRC : hs;
            end else begin
                n_didx = r_didx + 2'd1;
            end
        end else if (accept && i_last) begin
            if (!n_fill[2]) begin
                vpush = 1'b1;
                stt = cpc_pkg::ST_SHORT;
            end else if (n_phase == cpc_pkg::PH_BODY || n_phase == cpc_pkg::PH_DEAD) begin
                vpush = 1'b1;
                if (n_phase == cpc_pkg::PH_BODY) begin
                    hdr_ok = 1'b1;
                    if (n_err[cpc_pkg::ERR_OVER] || n_sum > n_body) hs = cpc_pkg::ST_OVER;
                    else if (n_sum < n_body) hs = cpc_pkg::ST_UNDER;
                    else if (n_err[cpc_pkg::ERR_COL]) hs = cpc_pkg::ST_COLUMN;
                    else hs = cpc_pkg::ST_OK;
                end else begin
                    hs = cpc_pkg::header_code(n_err);
                end
                stt = crc_bad ? cpc_pkg::ST_CRC : hs;
            end else begin
                // header still open: finish it over the CRC bytes
                n_drain = 1'b1;
                n_didx = 2'd0;
                n_crc_bad = crc_bad;
            end
        end
        clr = vpush;

        fp_o = hdr_ok & n_flags[0];
        pp_o = hdr_ok & n_flags[1];
        wc_o = hdr_ok ? n_win : '0;
        pc_o = hdr_ok ? n_pos : '0;
        win64 = 64'(wc_o);
        pos64 = 64'(pc_o);
        ent64 = 64'(got_idx);

        wr_d0 = '0;
        wr_d1 = '0;
        wr_d1.kind = cpc_pkg::KIND_VERDICT;
        wr_d1.freq_present = fp_o;
        wr_d1.prx_present = pp_o;
        wr_d1.window_count = win64[24:0];
        wr_d1.position_count = pos64[24:0];
        wr_d1.status = stt;
        if (got) begin
            wr_d0.kind = cpc_pkg::KIND_VALUE;
            wr_d0.column = got_col;
            wr_d0.entry_index = ent64[23:0];
            wr_d0.value = got_val;
            wr_cnt = vpush ? 2'd2 : 2'd1;
        end else begin
            wr_d0 = wr_d1;
            wr_cnt = vpush ? 2'd1 : 2'd0;
        end

        if (clr) begin
            for (int j = 0; j < 4; j++) n_tail[j] = 8'd0;
            for (int j = 0; j < 6; j++) n_len[j] = '0;
            n_fill = 3'd0;   n_crc = '1;      n_phase = cpc_pkg::PH_VER;
            n_vacc = 64'd0;  n_vsh = 4'd0;    n_win = '0;      n_pos = '0;
            n_sum = '0;      n_body = '0;     n_col = cpc_pkg::COL_MAXFREQ;
            n_left = '0;     n_ent = '0;      n_err = '0;      n_flags = 2'd0;
            n_drain = 1'b0;  n_didx = 2'd0;   n_crc_bad = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 4; j++) r_tail[j] <= 8'd0;
            for (int j = 0; j < 6; j++) r_len[j] <= '0;
            r_fill <= 3'd0;   r_crc <= '1;      r_phase <= cpc_pkg::PH_VER;
            r_vacc <= 64'd0;  r_vsh <= 4'd0;    r_win <= '0;      r_pos <= '0;
            r_sum <= '0;      r_body <= '0;     r_col <= cpc_pkg::COL_MAXFREQ;
            r_left <= '0;     r_ent <= '0;      r_err <= '0;      r_flags <= 2'd0;
            r_drain <= 1'b0;  r_didx <= 2'd0;   r_crc_bad <= 1'b0;
        end else begin
            r_tail <= n_tail; r_len <= n_len;
            r_fill <= n_fill; r_crc <= n_crc;   r_phase <= n_phase;
            r_vacc <= n_vacc; r_vsh <= n_vsh;   r_win <= n_win;   r_pos <= n_pos;
            r_sum <= n_sum;   r_body <= n_body; r_col <= n_col;
            r_left <= n_left; r_ent <= n_ent;   r_err <= n_err;   r_flags <= n_flags;
            r_drain <= n_drain; r_didx <= n_didx; r_crc_bad <= n_crc_bad;
        end
    end

    cpc_outq #(
        .WIDTH($bits(cpc_pkg::t_result))
    ) u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_cnt   (wr_cnt),
        .i_wr_data0 (wr_d0),
        .i_wr_data1 (wr_d1),
        .o_room2    (q_room),
        .o_valid    (q_valid),
        .o_data     (q_head),
        .i_ready    (i_ready)
    );

    assign o_valid          = q_valid;
    assign o_kind           = q_head.kind;
    assign o_column         = q_head.column;
    assign o_entry_index    = q_head.entry_index;
    assign o_value          = q_head.value;
    assign o_freq_present   = q_head.freq_present;
    assign o_prx_present    = q_head.prx_present;
    assign o_window_count   = q_head.window_count;
    assign o_position_count = q_head.position_count;
    assign o_status         = q_head.status;

    a_value_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == cpc_pkg::KIND_VALUE) |->
            (o_status == cpc_pkg::ST_OK && o_window_count == 25'd0 && !o_prx_present))
        else $error("value result carries verdict fields");

    a_drain_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_drain && $past(r_drain, 1) && $past(r_drain, 2) && $past(r_drain, 3) &&
          $past(r_drain, 4)))
        else $error("tail header walk ran past four bytes");

    a_fill_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill[2] |-> (r_fill[1:0] == 2'd0))
        else $error("tail fill count beyond four");

    a_entries_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == cpc_pkg::PH_BODY && r_col < cpc_pkg::COL_DONE) |-> (r_ent <= w_cur_count))
        else $error("column entries exceed header count");

endmodule

>>> sv/cpc_outq.sv
// Four-entry result queue that takes up to two results per cycle.
module cpc_outq #(
    parameter int WIDTH = 148
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_wr_cnt,
    input  logic [WIDTH-1:0] i_wr_data0,
    input  logic [WIDTH-1:0] i_wr_data1,
    output logic             o_room2,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_ready
);
    logic [WIDTH-1:0] r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       pop;

    assign o_valid = (r_cnt != 3'd0);
    assign o_data  = r_mem[r_rp];
    assign o_room2 = (r_cnt <= 3'd2);
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wp  <= r_wp + i_wr_cnt;
            r_rp  <= r_rp + {1'b0, pop};
            r_cnt <= r_cnt + {1'b0, i_wr_cnt} - {2'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_cnt != 2'd0) begin
            r_mem[r_wp] <= i_wr_data0;
        end
        if (i_wr_cnt == 2'd2) begin
            r_mem[r_wp + 2'd1] <= i_wr_data1;
        end
    end

endmodule
